// ===== rtl/u8trunc_pkg.sv =====
// Shared types and constants of the UTF-8 safe line truncator.
package u8trunc_pkg;

   localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
   localparam logic [7:0] CONT_MASK      = 8'hC0;
   localparam logic [7:0] CONT_TAG       = 8'h80;
   localparam int         MARK_LEN       = 15;
   localparam int         CUT_BACKOFF    = 16;
   localparam int         THRESHOLD_W    = 9;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 9'd256;
   localparam logic [1:0] REG_THRESHOLD  = 2'd0;

   // One byte handed from the sequencer to the packer.
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } push_type;

   // Marker text " \xE2\x80\xA6[truncated]".
   function automatic logic [7:0] mark_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'h20;
         4'd1:    b = 8'hE2;
         4'd2:    b = 8'h80;
         4'd3:    b = 8'hA6;
         4'd4:    b = 8'h5B;
         4'd5:    b = 8'h74;
         4'd6:    b = 8'h72;
         4'd7:    b = 8'h75;
         4'd8:    b = 8'h6E;
         4'd9:    b = 8'h63;
         4'd10:   b = 8'h61;
         4'd11:   b = 8'h74;
         4'd12:   b = 8'h65;
         4'd13:   b = 8'h64;
         4'd14:   b = 8'h5D;
         default: b = NEWLINE_BYTE;
      endcase
      return b;
   endfunction

endpackage

// ===== rtl/u8trunc_req_if.sv =====
// Input channel: one text byte per beat.
interface u8trunc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

// ===== rtl/u8trunc_rsp_if.sv =====
// Result channel: up to eight packed output bytes per beat.
interface u8trunc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_bytes;
   logic [3:0]  byte_count;
   logic        run_end;

   modport source (output valid, output out_bytes, output byte_count, output run_end,
                   input ready);
   modport sink   (input valid, input out_bytes, input byte_count, input run_end,
                   output ready);
endinterface

// ===== rtl/u8trunc_line_ram.sv =====
// Line buffer: one write port, one registered read port.
module u8trunc_line_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data_ff
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== rtl/u8trunc_packer.sv =====
// Packs single bytes into 8-byte result beats behind an output register.
module u8trunc_packer (
   input  logic                  clock,
   input  logic                  reset,
   input  u8trunc_pkg::push_type push,
   output logic                  push_ready,
   u8trunc_rsp_if.source         rsp_bus
);

   logic [63:0] word_ff,  word_in;
   logic [3:0]  cnt_ff,   cnt_in;
   logic        full_ff,  full_in;
   logic        last_ff,  last_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_bytes_ff, out_bytes_in;
   logic [3:0]  out_count_ff, out_count_in;
   logic        out_end_ff,   out_end_in;
   logic        drain;

   assign push_ready = !full_ff;
   assign drain      = full_ff && (!out_valid_ff || rsp_bus.ready);

   always_comb begin
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      out_bytes_in = out_bytes_ff;
      out_count_in = out_count_ff;
      out_end_in   = out_end_ff;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (drain) begin
         out_valid_in = 1'b1;
         out_bytes_in = word_ff;
         out_count_in = cnt_ff;
         out_end_in   = last_ff;
         word_in      = '0;
         cnt_in       = '0;
         full_in      = 1'b0;
      end else if (push.valid && !full_ff) begin
         for (int b = 0; b < 8; b++) begin
            if (cnt_ff[2:0] == 3'(b)) begin
               word_in[8*b +: 8] = push.data;
            end
         end
         cnt_in  = cnt_ff + 4'd1;
         last_in = push.last;
         full_in = push.last || (cnt_ff == 4'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         cnt_ff       <= '0;
         full_ff      <= 1'b0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         word_ff      <= word_in;
         cnt_ff       <= cnt_in;
         full_ff      <= full_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
      out_bytes_ff <= out_bytes_in;
      out_count_ff <= out_count_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_bytes  = out_bytes_ff;
   assign rsp_bus.byte_count = out_count_ff;
   assign rsp_bus.run_end    = out_end_ff;

endmodule

// ===== rtl/utf8_safe_line_truncator.sv =====
// UTF-8 safe line truncator: top level with the byte sequencer and config port.
//
// Bytes enter on req_bus, one per beat. A byte that does not close a line, or
// any byte of a line tail being dropped, gives no result unless it overflows
// the line. A newline or end_of_input byte releases the buffered line; a byte
// that would push the line past line_threshold, capped at LINE_BYTES, releases
// the first cut bytes, the 15-byte marker and a newline. Results leave on
// rsp_bus, up to eight bytes a beat, run_end on the last beat of the burst.
// A released burst fetches each byte from the line RAM and then pushes it
// into the packer; a truncation first walks back byte by byte from the cut
// point. req_bus is ready only while idle, not during a walk-back or while
// a burst is produced. The packer holds one full word and one output
// register, so a stalled receiver stops the sequencer only once both are
// occupied. Reset clears the line length, the drop flag and all handshake
// state and sets line_threshold to 256; the line RAM is not cleared.
// line_threshold reads at csr_ address 0 and is written at any csr_ address;
// it must be changed by the user only while idle; the block does not enforce it.
module utf8_safe_line_truncator #(
   parameter int LINE_BYTES = 256
) (
   input  logic                clock,
   input  logic                reset,
   u8trunc_req_if.sink         req_bus,
   u8trunc_rsp_if.source       rsp_bus,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [1:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int AW = $clog2(LINE_BYTES);
   localparam int LW = $clog2(LINE_BYTES + 1);
   localparam int CW = $clog2(LINE_BYTES + u8trunc_pkg::CUT_BACKOFF + 1);
   localparam logic [LW-1:0] LIMIT_MAX = LW'(LINE_BYTES);
   localparam logic [9:0]    DEPTH_10  = 10'(LINE_BYTES);
   localparam int TW = u8trunc_pkg::THRESHOLD_W;

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FETCH, ST_APPEND} state_type;

   state_type       state_ff,   state_in;
   logic [LW-1:0]   len_ff,     len_in;
   logic            discard_ff, discard_in;
   logic [LW-1:0]   walk_ff,    walk_in;
   logic [LW-1:0]   body_ff,    body_in;
   logic            mark_ff,    mark_in;
   logic [CW-1:0]   total_ff,   total_in;
   logic [CW-1:0]   idx_ff,     idx_in;
   logic [TW-1:0]   thr_ff;

   logic [LW-1:0]   limit;
   logic [LW-1:0]   cut0;
   logic [LW-1:0]   walk_dec;
   logic [CW-1:0]   idx_next;
   logic [CW-1:0]   mark_off;
   logic            accept;
   logic            line_end;
   logic            is_cont;
   logic            wr_en;
   logic [AW-1:0]   rd_addr;
   logic [7:0]      rd_data;
   logic            push_ready;
   u8trunc_pkg::push_type push;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= u8trunc_pkg::THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         thr_ff <= csr_pwdata[TW-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == u8trunc_pkg::REG_THRESHOLD) ? {{(32-TW){1'b0}}, thr_ff}
                                                                 : '0;

   // ---- sequencer ----
   assign limit    = ({1'b0, thr_ff} > DEPTH_10) ? LIMIT_MAX : LW'(thr_ff);
   assign cut0     = (limit >= LW'(u8trunc_pkg::CUT_BACKOFF))
                   ? limit - LW'(u8trunc_pkg::CUT_BACKOFF) : '0;
   assign walk_dec = walk_ff - LW'(1);
   assign idx_next = idx_ff + CW'(1);
   assign mark_off = idx_ff - CW'(body_ff);
   assign accept   = req_bus.valid && req_bus.ready;
   assign line_end = (req_bus.data_byte == u8trunc_pkg::NEWLINE_BYTE) || req_bus.end_of_input;
   assign is_cont  = (rd_data & u8trunc_pkg::CONT_MASK) == u8trunc_pkg::CONT_TAG;
   assign req_bus.ready = (state_ff == ST_IDLE);

   assign wr_en = accept && !discard_ff && (len_ff < limit);

   always_comb begin
      case (state_ff)
         ST_IDLE: rd_addr = cut0[AW-1:0];
         ST_WALK: rd_addr = walk_dec[AW-1:0];
         default: rd_addr = idx_ff[AW-1:0];
      endcase
   end

   always_comb begin
      push.valid = (state_ff == ST_APPEND);
      push.last  = (idx_next == total_ff);
      if (idx_ff < CW'(body_ff)) begin
         push.data = rd_data;
      end else if (mark_off < CW'(u8trunc_pkg::MARK_LEN)) begin
         push.data = u8trunc_pkg::mark_byte(mark_off[3:0]);
      end else begin
         push.data = u8trunc_pkg::NEWLINE_BYTE;
      end
   end

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      discard_in = discard_ff;
      walk_in    = walk_ff;
      body_in    = body_ff;
      mark_in    = mark_ff;
      total_in   = total_ff;
      idx_in     = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (discard_ff) begin
                  if (line_end) begin
                     discard_in = 1'b0;
                     len_in     = '0;
                  end
               end else if (len_ff >= limit) begin
                  // line overflows: cut back to a character boundary
                  len_in     = '0;
                  discard_in = !line_end;
                  mark_in    = 1'b1;
                  walk_in    = cut0;
                  idx_in     = '0;
                  if (cut0 == '0) begin
                     body_in  = '0;
                     total_in = CW'(u8trunc_pkg::MARK_LEN + 1);
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_WALK;
                  end
               end else if (line_end) begin
                  len_in   = '0;
                  mark_in  = 1'b0;
                  body_in  = len_ff + LW'(1);
                  total_in = CW'(len_ff) + CW'(1);
                  idx_in   = '0;
                  state_in = ST_FETCH;
               end else begin
                  len_in = len_ff + LW'(1);
               end
            end
         end
         ST_WALK: begin
            if (is_cont) begin
               walk_in = walk_dec;
               if (walk_dec == '0) begin
                  body_in  = '0;
                  total_in = CW'(u8trunc_pkg::MARK_LEN + 1);
                  state_in = ST_FETCH;
               end
            end else begin
               body_in  = walk_ff;
               total_in = CW'(walk_ff) + CW'(u8trunc_pkg::MARK_LEN + 1);
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_APPEND;
         end
         ST_APPEND: begin
            if (push_ready) begin
               idx_in   = idx_next;
               state_in = push.last ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_ff     <= '0;
         discard_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         discard_ff <= discard_in;
      end
      walk_ff  <= walk_in;
      body_ff  <= body_in;
      mark_ff  <= mark_in;
      total_ff <= total_in;
      idx_ff   <= idx_in;
   end

   u8trunc_line_ram #(
      .DEPTH (LINE_BYTES),
      .AW    (AW)
   ) u_line_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (len_ff[AW-1:0]),
      .wr_data    (req_bus.data_byte),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   u8trunc_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .rsp_bus    (rsp_bus)
   );

   // ---- checks ----
   a_discard_empty: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (len_ff == '0))
      else $error("line length nonzero while dropping a line tail");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LIMIT_MAX)
      else $error("line length beyond buffer depth");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_APPEND) |-> (idx_ff < total_ff))
      else $error("burst index past burst length");

   a_beat_count: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.byte_count != 4'd0 && rsp_bus.byte_count <= 4'd8))
      else $error("result beat with bad byte count");

   a_mark_mark: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |=> (mark_ff && !req_bus.ready))
      else $error("walk-back left without a marked burst");

endmodule
